### rtl/core/clcd_pkg.sv
// clcd_pkg: shared types, command codes and byte tables for the character lcd writer
// no dependencies; imported by char_lcd_text_writer and tb_top

package clcd_pkg;

    // command codes carried on the input tuser
    typedef enum logic [3:0] {
        CMD_INIT      = 4'd0,
        CMD_LOCATE    = 4'd1,
        CMD_CHAR      = 4'd2,
        CMD_HEX_BYTE  = 4'd3,
        CMD_HEX_WORD  = 4'd4,
        CMD_DECIMAL   = 4'd5,
        CMD_CUR_SHOW  = 4'd6,
        CMD_CUR_SHIFT = 4'd7,
        CMD_CLEAR_ROW = 4'd8
    } cmd_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT_RAW,
        ST_PREP,
        ST_DIV,
        ST_DIGIT,
        ST_SEND_HI,
        ST_SEND_LO
    } state_t;

    // instruction and data bytes
    localparam logic [7:0] LCD_FUNC_SET    = 8'h28;
    localparam logic [7:0] LCD_CLEAR       = 8'h01;
    localparam logic [7:0] LCD_DISP_CURSOR = 8'h0F;
    localparam logic [7:0] LCD_DISP_PLAIN  = 8'h0C;
    localparam logic [7:0] LCD_SHIFT_RIGHT = 8'h14;
    localparam logic [7:0] LCD_SHIFT_LEFT  = 8'h10;
    localparam logic [7:0] LCD_SPACE       = 8'h20;
    localparam logic [7:0] ASCII_ZERO      = 8'h30;
    localparam logic [7:0] ASCII_NINE      = 8'h39;
    localparam logic [7:0] HEX_ALPHA_GAP   = 8'h07;

    // raw wake-up nibbles of the 4-bit init sequence
    localparam logic [3:0] INIT_NIB      = 4'h3;
    localparam logic [3:0] INIT_NIB_LAST = 4'h2;
    localparam logic [1:0] INIT_RAW_LAST = 2'd3;
    localparam logic [1:0] INIT_BYTE_LAST = 2'd2;

    // register select codes
    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    // ddram start address of each row
    function automatic logic [7:0] row_start(input logic [1:0] row);
        logic [7:0] addr;
        unique case (row)
            2'd0:    addr = 8'h80;
            2'd1:    addr = 8'hC0;
            2'd2:    addr = 8'h90;
            default: addr = 8'hD0;
        endcase
        return addr;
    endfunction

    // digit to character, 8-bit wrap as on the display side
    function automatic logic [7:0] hex_char(input logic [7:0] d);
        logic [7:0] c;
        c = d + ASCII_ZERO;
        if (c > ASCII_NINE)
            c = c + HEX_ALPHA_GAP;
        return c;
    endfunction

    // decimal place weight 10^(k-1) modulo 2^16
    function automatic logic [15:0] dec_divisor(input logic [2:0] k);
        logic [15:0] d;
        unique case (k)
            3'd2:    d = 16'd10;
            3'd3:    d = 16'd100;
            3'd4:    d = 16'd1000;
            3'd5:    d = 16'd10000;
            3'd6:    d = 16'd34464;
            3'd7:    d = 16'd16960;
            default: d = 16'd1;
        endcase
        return d;
    endfunction

endpackage

### rtl/core/char_lcd_text_writer.sv
// a taken item with bytes to send goes to ST_PREP (through ST_INIT_RAW for init), which picks each byte, then
// ST_SEND_HI and ST_SEND_LO queue its nibbles; each decimal digit first runs the divider in ST_DIV
// and is shaped in ST_DIGIT; one item at a time, ready again the cycle after the last nibble is queued;
// a decimal's digits come from the one-bit-per-cycle shared divider
// reset: asynchronous, active low; sequencer idle, output empty, cursor shown (0x0F)
// char_lcd_text_writer: command to 4-bit lcd nibble stream, depends on clcd_pkg

module char_lcd_text_writer
    import clcd_pkg::*;
#(
    parameter int ROW_CHARS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // with_locate[0], column[6:1], row[8:7], value[24:9], digit_count[27:25],
    // show_leading_zeros[28], switch_on[29], zero pad[31:30]
    input  logic [31:0] s_axis_tdata,
    // command[3:0]
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // bus_nibble[3:0], zero pad[7:4]
    output logic [7:0]  m_axis_tdata,
    // register_select[0]
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int CNT_RAW = $clog2(ROW_CHARS + 1);
    localparam int CNT_W   = (CNT_RAW > 2) ? CNT_RAW : 2;
    localparam logic [CNT_W-1:0] FILL_LAST = CNT_W'(ROW_CHARS - 1);

    // input field unpack
    logic        in_loc;
    logic [5:0]  in_col;
    logic [1:0]  in_row;
    logic [15:0] in_val;
    logic [2:0]  in_digits;
    logic        in_lead;
    logic        in_sw;
    cmd_t        in_cmd;
    logic        in_acc;

    assign in_loc    = s_axis_tdata[0];
    assign in_col    = s_axis_tdata[6:1];
    assign in_row    = s_axis_tdata[8:7];
    assign in_val    = s_axis_tdata[24:9];
    assign in_digits = s_axis_tdata[27:25];
    assign in_lead   = s_axis_tdata[28];
    assign in_sw     = s_axis_tdata[29];
    assign in_cmd    = cmd_t'(s_axis_tuser);
    assign in_acc    = s_axis_tvalid && s_axis_tready;

    // control registers
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   cursor_shown_reg, cursor_shown_next;

    // payload registers
    cmd_t             cmd_reg, cmd_next;
    logic             loc_phase_reg, loc_phase_next;
    logic [5:0]       col_reg, col_next;
    logic [1:0]       row_reg, row_next;
    logic [15:0]      val_reg, val_next;
    logic [2:0]       k_reg, k_next;
    logic             shown_reg, shown_next;
    logic             sw_reg, sw_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       byte_reg, byte_next;
    logic             byte_rs_reg, byte_rs_next;
    logic             byte_last_reg, byte_last_next;
    logic [15:0]      rem_reg, rem_next;
    logic [15:0]      div_reg, div_next;
    logic [15:0]      quo_reg, quo_next;
    logic [15:0]      part_reg, part_next;
    logic [3:0]       bit_cnt_reg, bit_cnt_next;
    logic [3:0]       out_nib_reg, out_nib_next;
    logic             out_rs_reg, out_rs_next;
    logic             out_last_reg, out_last_next;

    // shared divider datapath and digit shaping
    logic        out_free;
    logic [16:0] trial_w;
    logic [16:0] diff_w;
    logic [23:0] prod_w;
    logic        blank_w;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign trial_w  = {part_reg, quo_reg[15]};
    assign diff_w   = trial_w - {1'b0, div_reg};
    assign prod_w   = {16'b0, quo_reg[7:0]} * {8'b0, div_reg};
    assign blank_w  = !shown_reg && (quo_reg[7:0] == 8'd0) && (k_reg != 3'd1);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_nib_reg};
    assign m_axis_tuser  = out_rs_reg;
    assign m_axis_tlast  = out_last_reg;

    // sequencer: next state and datapath control
    always_comb
    begin
        state_next        = state_reg;
        cursor_shown_next = cursor_shown_reg;
        cmd_next          = cmd_reg;
        loc_phase_next    = loc_phase_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        val_next          = val_reg;
        k_next            = k_reg;
        shown_next        = shown_reg;
        sw_next           = sw_reg;
        cnt_next          = cnt_reg;
        byte_next         = byte_reg;
        byte_rs_next      = byte_rs_reg;
        byte_last_next    = byte_last_reg;
        rem_next          = rem_reg;
        div_next          = div_reg;
        quo_next          = quo_reg;
        part_next         = part_reg;
        bit_cnt_next      = bit_cnt_reg;
        out_nib_next      = out_nib_reg;
        out_rs_next       = out_rs_reg;
        out_last_next     = out_last_reg;
        out_valid_next    = out_valid_reg && !m_axis_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cmd_next       = in_cmd;
                    col_next       = (in_cmd == CMD_CLEAR_ROW) ? 6'd0 : in_col;
                    row_next       = in_row;
                    val_next       = in_val;
                    rem_next       = in_val;
                    k_next         = in_digits;
                    shown_next     = in_lead;
                    sw_next        = in_sw;
                    cnt_next       = '0;
                    loc_phase_next = (in_cmd == CMD_LOCATE) || (in_cmd == CMD_CLEAR_ROW)
                                     || (in_loc && ((in_cmd == CMD_CHAR)
                                     || (in_cmd == CMD_HEX_BYTE) || (in_cmd == CMD_HEX_WORD)
                                     || (in_cmd == CMD_DECIMAL)));
                    case (in_cmd)
                        CMD_INIT:
                        begin
                            cursor_shown_next = 1'b1;
                            state_next        = ST_INIT_RAW;
                        end
                        CMD_CUR_SHOW:
                        begin
                            cursor_shown_next = in_sw;
                            state_next        = ST_PREP;
                        end
                        CMD_LOCATE, CMD_CHAR, CMD_HEX_BYTE, CMD_HEX_WORD,
                        CMD_CUR_SHIFT, CMD_CLEAR_ROW:
                        begin
                            state_next = ST_PREP;
                        end
                        CMD_DECIMAL:
                        begin
                            // nothing to send without digits or locate
                            if (in_loc || (in_digits != 3'd0))
                                state_next = ST_PREP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // raw wake-up nibbles before the byte-wide init
            ST_INIT_RAW:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_nib_next   = (cnt_reg[1:0] == INIT_RAW_LAST) ? INIT_NIB_LAST : INIT_NIB;
                    out_rs_next    = RS_INSTR;
                    out_last_next  = 1'b0;
                    if (cnt_reg[1:0] == INIT_RAW_LAST)
                    begin
                        cnt_next   = '0;
                        state_next = ST_PREP;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end

            // pick the next byte of the command
            ST_PREP:
            begin
                state_next     = ST_SEND_HI;
                byte_rs_next   = RS_DATA;
                byte_last_next = 1'b1;
                cnt_next       = cnt_reg + 1'b1;
                if (loc_phase_reg)
                begin
                    loc_phase_next = 1'b0;
                    cnt_next       = cnt_reg;
                    byte_next      = row_start(row_reg) + {2'b0, col_reg};
                    byte_rs_next   = RS_INSTR;
                    byte_last_next = (cmd_reg == CMD_LOCATE)
                                     || ((cmd_reg == CMD_DECIMAL) && (k_reg == 3'd0));
                end
                else
                begin
                    case (cmd_reg)
                        CMD_INIT:
                        begin
                            byte_rs_next   = RS_INSTR;
                            byte_last_next = (cnt_reg[1:0] == INIT_BYTE_LAST);
                            case (cnt_reg[1:0])
                                2'd0:    byte_next = LCD_FUNC_SET;
                                2'd1:    byte_next = cursor_shown_reg ? LCD_DISP_CURSOR
                                                                      : LCD_DISP_PLAIN;
                                default: byte_next = LCD_CLEAR;
                            endcase
                        end
                        CMD_CHAR:
                        begin
                            byte_next = val_reg[7:0];
                        end
                        CMD_HEX_BYTE:
                        begin
                            byte_last_next = cnt_reg[0];
                            byte_next      = hex_char({4'b0, cnt_reg[0] ? val_reg[3:0]
                                                                        : val_reg[7:4]});
                        end
                        CMD_HEX_WORD:
                        begin
                            byte_last_next = (cnt_reg[1:0] == 2'd3);
                            case (cnt_reg[1:0])
                                2'd0:    byte_next = hex_char({4'b0, val_reg[15:12]});
                                2'd1:    byte_next = hex_char({4'b0, val_reg[11:8]});
                                2'd2:    byte_next = hex_char({4'b0, val_reg[7:4]});
                                default: byte_next = hex_char({4'b0, val_reg[3:0]});
                            endcase
                        end
                        CMD_DECIMAL:
                        begin
                            // start the shared divider on this place weight
                            state_next   = ST_DIV;
                            cnt_next     = cnt_reg;
                            div_next     = dec_divisor(k_reg);
                            quo_next     = rem_reg;
                            part_next    = 16'd0;
                            bit_cnt_next = 4'd0;
                        end
                        CMD_CUR_SHOW:
                        begin
                            byte_rs_next = RS_INSTR;
                            byte_next    = cursor_shown_reg ? LCD_DISP_CURSOR : LCD_DISP_PLAIN;
                        end
                        CMD_CUR_SHIFT:
                        begin
                            byte_rs_next = RS_INSTR;
                            byte_next    = sw_reg ? LCD_SHIFT_RIGHT : LCD_SHIFT_LEFT;
                        end
                        CMD_CLEAR_ROW:
                        begin
                            byte_next      = LCD_SPACE;
                            byte_last_next = (cnt_reg == FILL_LAST);
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // restoring division, one quotient bit per cycle
            ST_DIV:
            begin
                if (!diff_w[16])
                begin
                    part_next = diff_w[15:0];
                    quo_next  = {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    part_next = trial_w[15:0];
                    quo_next  = {quo_reg[14:0], 1'b0};
                end
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == 4'd15)
                    state_next = ST_DIGIT;
            end

            // turn the 8-bit quotient into a digit or a blank
            ST_DIGIT:
            begin
                byte_next      = blank_w ? LCD_SPACE : hex_char(quo_reg[7:0]);
                byte_rs_next   = RS_DATA;
                byte_last_next = (k_reg == 3'd1);
                shown_next     = shown_reg || !blank_w;
                rem_next       = rem_reg - prod_w[15:0];
                k_next         = k_reg - 1'b1;
                state_next     = ST_SEND_HI;
            end

            ST_SEND_HI:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_nib_next   = byte_reg[7:4];
                    out_rs_next    = byte_rs_reg;
                    out_last_next  = 1'b0;
                    state_next     = ST_SEND_LO;
                end
            end

            ST_SEND_LO:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_nib_next   = byte_reg[3:0];
                    out_rs_next    = byte_rs_reg;
                    out_last_next  = byte_last_reg;
                    state_next     = byte_last_reg ? ST_IDLE : ST_PREP;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            cursor_shown_reg <= 1'b1;
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            cursor_shown_reg <= cursor_shown_next;
        end
    end

    // payload and datapath
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        loc_phase_reg <= loc_phase_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        val_reg       <= val_next;
        k_reg         <= k_next;
        shown_reg     <= shown_next;
        sw_reg        <= sw_next;
        cnt_reg       <= cnt_next;
        byte_reg      <= byte_next;
        byte_rs_reg   <= byte_rs_next;
        byte_last_reg <= byte_last_next;
        rem_reg       <= rem_next;
        div_reg       <= div_next;
        quo_reg       <= quo_next;
        part_reg      <= part_next;
        bit_cnt_reg   <= bit_cnt_next;
        out_nib_reg   <= out_nib_next;
        out_rs_reg    <= out_rs_next;
        out_last_reg  <= out_last_next;
    end

`ifndef SYNTH
    // divider never runs on a zero weight
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_reg != 16'd0))
        else $error("divider started with zero weight");

    // partial remainder stays below the weight once the quotient is done
    a_part_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGIT) |-> (part_reg < div_reg))
        else $error("partial remainder out of range");

    // a digit is only formed while digits remain
    a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGIT) |-> (k_reg != 3'd0))
        else $error("digit formed with no digits left");

    // cursor visibility only moves when an item is taken
    a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cursor_shown_reg) |-> $past(in_acc))
        else $error("cursor state changed without an item");
`endif

endmodule

### dv/tb_top.sv
// tb_top: self-checking testbench for char_lcd_text_writer, the command to 4-bit lcd nibble stream
// depends on clcd_pkg and the char_lcd_text_writer rtl; the expected transfers come from an
// in-bench predictor, and random gaps and stalls are applied on both stream ports

`timescale 1ns / 1ps

module tb_top;

    import clcd_pkg::*;

    // one command item as driven on the input stream
    typedef struct {
        logic [3:0]  cmd;
        logic        with_locate;
        logic [5:0]  column;
        logic [1:0]  row;
        logic [15:0] value;
        logic [2:0]  digits;
        logic        show_zeros;
        logic        switch_on;
        int          gap;
        bit          hold;
    } lcd_cmd_t;

    // one nibble transfer on the lcd bus
    typedef struct {
        logic [3:0] nibble;
        logic       rs;
        logic       last;
    } lcd_xfer_t;

    localparam int ROW_CHARS = 16;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [3:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    lcd_cmd_t  cmd_q[$];
    lcd_xfer_t lcd_xfer_q[$];
    lcd_xfer_t cmd_xfers[$];
    lcd_cmd_t  tx_cur;

    logic [7:0] lcd_row_base [4] = '{8'h80, 8'hC0, 8'h90, 8'hD0};
    logic       cursor_on;

    int  errors;
    int  tx_offered;
    int  tx_taken;
    int  tx_gap_left;
    int  rx_taken;
    int  rx_seen;
    int  rx_stall_left;
    bit  rx_calm;
    int  total_cmds;
    int  cmd_count [16];

    char_lcd_text_writer #(
        .ROW_CHARS(ROW_CHARS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 30)
            $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // transfer builders for the predictor
    task automatic xfer_nib(input logic [3:0] nib, input logic rs);
        lcd_xfer_t x;
        x.nibble = nib;
        x.rs = rs;
        x.last = 1'b0;
        cmd_xfers.push_back(x);
    endtask

    task automatic xfer_byte(input logic [7:0] b, input logic rs);
        xfer_nib(b[7:4], rs);
        xfer_nib(b[3:0], rs);
    endtask

    task automatic xfer_addr(input logic [5:0] col, input logic [1:0] row);
        logic [7:0] addr;
        addr = lcd_row_base[row] + {2'b00, col};
        xfer_byte(addr, RS_INSTR);
    endtask

    // digit to character with 8-bit wrap, letters past nine
    task automatic xfer_hex(input logic [7:0] d);
        logic [7:0] c;
        c = d + ASCII_ZERO;
        if (c > ASCII_NINE)
            c = c + HEX_ALPHA_GAP;
        xfer_byte(c, RS_DATA);
    endtask

    // works out the bus transfers of one accepted command
    task automatic lcd_expect_cmd(input lcd_cmd_t it);
        logic [15:0] rem;
        logic [15:0] div;
        logic [15:0] quo;
        logic [31:0] prod;
        logic [7:0]  q;
        logic        lead;
        lcd_xfer_t   x;
        int          k;
        int          t;
        int          i;
        cmd_xfers.delete();
        if (it.cmd >= CMD_CHAR && it.cmd <= CMD_DECIMAL && it.with_locate)
            xfer_addr(it.column, it.row);
        case (it.cmd)
            CMD_INIT:
            begin
                cursor_on = 1'b1;
                xfer_nib(INIT_NIB, RS_INSTR);
                xfer_nib(INIT_NIB, RS_INSTR);
                xfer_nib(INIT_NIB, RS_INSTR);
                xfer_nib(INIT_NIB_LAST, RS_INSTR);
                xfer_byte(LCD_FUNC_SET, RS_INSTR);
                xfer_byte(LCD_DISP_CURSOR, RS_INSTR);
                xfer_byte(LCD_CLEAR, RS_INSTR);
            end
            CMD_LOCATE:
                xfer_addr(it.column, it.row);
            CMD_CHAR:
                xfer_byte(it.value[7:0], RS_DATA);
            CMD_HEX_BYTE:
            begin
                xfer_hex({4'h0, it.value[7:4]});
                xfer_hex({4'h0, it.value[3:0]});
            end
            CMD_HEX_WORD:
                for (i = 3; i >= 0; i--)
                    xfer_hex({4'h0, it.value[4*i +: 4]});
            CMD_DECIMAL:
            begin
                // place weights and quotients wrap at 16 and 8 bits
                rem = it.value;
                lead = it.show_zeros;
                for (k = it.digits; k >= 1; k--)
                begin
                    div = 16'd1;
                    for (t = 1; t < k; t++)
                        div = div * 16'd10;
                    quo = rem / div;
                    q = quo[7:0];
                    if (!lead && q == 8'd0 && k != 1)
                        xfer_byte(LCD_SPACE, RS_DATA);
                    else
                    begin
                        xfer_hex(q);
                        lead = 1'b1;
                    end
                    prod = q * div;
                    rem = rem - prod[15:0];
                end
            end
            CMD_CUR_SHOW:
            begin
                cursor_on = it.switch_on;
                xfer_byte(cursor_on ? LCD_DISP_CURSOR : LCD_DISP_PLAIN, RS_INSTR);
            end
            CMD_CUR_SHIFT:
                xfer_byte(it.switch_on ? LCD_SHIFT_RIGHT : LCD_SHIFT_LEFT, RS_INSTR);
            CMD_CLEAR_ROW:
            begin
                xfer_addr(6'd0, it.row);
                for (i = 0; i < ROW_CHARS; i++)
                    xfer_byte(LCD_SPACE, RS_DATA);
            end
            default:
                ;
        endcase
        // mark the final transfer and queue the lot
        for (i = 0; i < cmd_xfers.size(); i++)
        begin
            x = cmd_xfers[i];
            x.last = (i == cmd_xfers.size() - 1);
            lcd_xfer_q.push_back(x);
        end
    endtask

    task automatic add_cmd(input logic [3:0] cmd, input logic loc, input logic [5:0] col,
                           input logic [1:0] row, input logic [15:0] val,
                           input logic [2:0] dig, input logic zeros, input logic sw,
                           input int gap, input bit hold);
        lcd_cmd_t it;
        it.cmd = cmd;
        it.with_locate = loc;
        it.column = col;
        it.row = row;
        it.value = val;
        it.digits = dig;
        it.show_zeros = zeros;
        it.switch_on = sw;
        it.gap = gap;
        it.hold = hold;
        cmd_q.push_back(it);
    endtask

    // random command, weighted towards the display output commands
    task automatic add_random_cmd(input bit calm, input bit hold);
        int          r;
        logic [3:0]  cmd;
        logic [15:0] val;
        logic [2:0]  dig;
        r = $urandom_range(0, 99);
        if (r < 4)
            cmd = CMD_INIT;
        else if (r < 12)
            cmd = CMD_LOCATE;
        else if (r < 24)
            cmd = CMD_CHAR;
        else if (r < 34)
            cmd = CMD_HEX_BYTE;
        else if (r < 44)
            cmd = CMD_HEX_WORD;
        else if (r < 72)
            cmd = CMD_DECIMAL;
        else if (r < 80)
            cmd = CMD_CUR_SHOW;
        else if (r < 88)
            cmd = CMD_CUR_SHIFT;
        else if (r < 95)
            cmd = CMD_CLEAR_ROW;
        else
            cmd = 4'($urandom_range(9, 15));
        r = $urandom_range(0, 3);
        if (r == 0)
            val = 16'($urandom_range(0, 99));
        else if (r == 1)
            val = 16'($urandom_range(0, 9999));
        else
            val = 16'($urandom);
        r = $urandom_range(0, 9);
        if (r == 0)
            dig = 3'd0;
        else if (r == 1)
            dig = 3'($urandom_range(6, 7));
        else
            dig = 3'($urandom_range(1, 5));
        add_cmd(cmd, 1'($urandom), 6'($urandom), 2'($urandom), val, dig, 1'($urandom),
                1'($urandom), calm ? 0 : $urandom_range(0, 6), hold);
    endtask

    // driver: presents each item at a falling edge after its gap, held ones once no transfer is due
    always @(negedge clk)
    begin : driver
        logic present;
        present = 1'b0;
        if (rst_n && (!s_axis_tvalid || tx_taken == tx_offered) && cmd_q.size() > 0)
        begin
            if (tx_gap_left < 0)
                tx_gap_left = cmd_q[0].gap;
            if (tx_gap_left > 0)
                tx_gap_left = tx_gap_left - 1;
            else if (!cmd_q[0].hold || lcd_xfer_q.size() == 0)
            begin
                tx_cur = cmd_q.pop_front();
                tx_gap_left = -1;
                tx_offered = tx_offered + 1;
                present = 1'b1;
            end
        end
        if (present)
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tuser <= tx_cur.cmd;
            s_axis_tdata <= {2'b00, tx_cur.switch_on, tx_cur.show_zeros, tx_cur.digits,
                             tx_cur.value, tx_cur.row, tx_cur.column, tx_cur.with_locate};
        end
        else if (rst_n && tx_taken == tx_offered)
            s_axis_tvalid <= 1'b0;
    end

    // receiver: drops ready for a random stall after each transfer, with no stalls in calm stretches
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_taken != rx_seen)
            begin
                rx_seen = rx_taken;
                if (rx_seen % 40 == 0)
                    rx_calm = ($urandom_range(0, 2) == 0);
                rx_stall_left = rx_calm ? 0 : $urandom_range(0, 6);
            end
            if (rx_stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_stall_left = rx_stall_left - 1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // capture: predicts on accepted items and checks accepted transfers
    always @(posedge clk)
    begin : capture
        lcd_xfer_t exp_x;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            lcd_expect_cmd(tx_cur);
            cmd_count[tx_cur.cmd] = cmd_count[tx_cur.cmd] + 1;
            tx_taken <= tx_taken + 1;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            rx_taken <= rx_taken + 1;
            if (lcd_xfer_q.size() == 0)
                report_mismatch($sformatf("transfer with nothing expected: data %h rs %b last %b",
                                          m_axis_tdata, m_axis_tuser, m_axis_tlast));
            else
            begin
                exp_x = lcd_xfer_q.pop_front();
                if (m_axis_tdata !== {4'h0, exp_x.nibble})
                    report_mismatch($sformatf("transfer %0d nibble: got %h expected %h",
                                              rx_taken, m_axis_tdata, exp_x.nibble));
                if (m_axis_tuser !== exp_x.rs)
                    report_mismatch($sformatf("transfer %0d register select: got %b expected %b",
                                              rx_taken, m_axis_tuser, exp_x.rs));
                if (m_axis_tlast !== exp_x.last)
                    report_mismatch($sformatf("transfer %0d last: got %b expected %b",
                                              rx_taken, m_axis_tlast, exp_x.last));
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int  n;
        bit  calm;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        cursor_on = 1'b1;
        errors = 0;
        tx_offered = 0;
        tx_taken = 0;
        tx_gap_left = -1;
        rx_taken = 0;
        rx_seen = 0;
        rx_stall_left = 0;
        rx_calm = 1'b0;
        for (n = 0; n < 16; n++)
            cmd_count[n] = 0;

        // directed: field extremes, every command and the corner cases
        add_cmd(CMD_INIT, 1'b1, 6'd63, 2'd3, 16'hFFFF, 3'd7, 1'b1, 1'b1, 0, 0);
        add_cmd(CMD_LOCATE, 1'b0, 6'd0, 2'd0, 16'h0000, 3'd0, 1'b0, 1'b0, 2, 0);
        // address wraps past 0xff
        add_cmd(CMD_LOCATE, 1'b1, 6'd63, 2'd3, 16'hFFFF, 3'd7, 1'b1, 1'b1, 0, 0);
        add_cmd(CMD_CHAR, 1'b0, 6'd5, 2'd1, 16'hFF00, 3'd0, 1'b0, 1'b0, 1, 0);
        add_cmd(CMD_CHAR, 1'b1, 6'd63, 2'd2, 16'h00FF, 3'd0, 1'b0, 1'b0, 0, 0);
        add_cmd(CMD_HEX_BYTE, 1'b0, 6'd0, 2'd0, 16'h0000, 3'd0, 1'b0, 1'b0, 3, 0);
        add_cmd(CMD_HEX_BYTE, 1'b1, 6'd17, 2'd1, 16'h12A9, 3'd0, 1'b0, 1'b0, 0, 0);
        add_cmd(CMD_HEX_WORD, 1'b0, 6'd0, 2'd0, 16'hFFFF, 3'd0, 1'b0, 1'b0, 0, 0);
        add_cmd(CMD_HEX_WORD, 1'b1, 6'd9, 2'd2, 16'h09AF, 3'd0, 1'b0, 1'b0, 6, 0);
        // no digits asked for: nothing emitted unless the locate prefix is on
        add_cmd(CMD_DECIMAL, 1'b0, 6'd0, 2'd0, 16'd1234, 3'd0, 1'b0, 1'b0, 0, 0);
        add_cmd(CMD_DECIMAL, 1'b1, 6'd3, 2'd1, 16'd1234, 3'd0, 1'b1, 1'b0, 0, 0);
        add_cmd(CMD_DECIMAL, 1'b0, 6'd0, 2'd0, 16'd65535, 3'd5, 1'b0, 1'b0, 0, 0);
        // leading blanks, last digit always shown
        add_cmd(CMD_DECIMAL, 1'b1, 6'd0, 2'd3, 16'd7, 3'd5, 1'b0, 1'b0, 1, 0);
        add_cmd(CMD_DECIMAL, 1'b0, 6'd0, 2'd0, 16'd0, 3'd3, 1'b0, 1'b0, 0, 0);
        add_cmd(CMD_DECIMAL, 1'b0, 6'd0, 2'd0, 16'd0, 3'd4, 1'b1, 1'b0, 0, 0);
        // oversized leading quotient and wrapped place weights
        add_cmd(CMD_DECIMAL, 1'b0, 6'd0, 2'd0, 16'd999, 3'd2, 1'b0, 1'b0, 0, 0);
        add_cmd(CMD_DECIMAL, 1'b0, 6'd0, 2'd0, 16'd65535, 3'd6, 1'b1, 1'b0, 4, 0);
        add_cmd(CMD_DECIMAL, 1'b1, 6'd40, 2'd2, 16'd12345, 3'd7, 1'b0, 1'b1, 0, 0);
        // cursor state, and init turning it back on
        add_cmd(CMD_CUR_SHOW, 1'b1, 6'd0, 2'd0, 16'h0000, 3'd0, 1'b0, 1'b0, 0, 0);
        add_cmd(CMD_INIT, 1'b0, 6'd0, 2'd0, 16'h0000, 3'd0, 1'b0, 1'b0, 0, 0);
        add_cmd(CMD_CUR_SHOW, 1'b0, 6'd0, 2'd0, 16'h0000, 3'd0, 1'b0, 1'b1, 2, 0);
        add_cmd(CMD_CUR_SHIFT, 1'b1, 6'd0, 2'd0, 16'h0000, 3'd0, 1'b0, 1'b1, 0, 0);
        add_cmd(CMD_CUR_SHIFT, 1'b0, 6'd0, 2'd0, 16'h0000, 3'd0, 1'b0, 1'b0, 0, 0);
        add_cmd(CMD_CLEAR_ROW, 1'b1, 6'd63, 2'd2, 16'hFFFF, 3'd5, 1'b1, 1'b1, 0, 0);
        // unused codes emit nothing
        add_cmd(4'd9, 1'b1, 6'd1, 2'd1, 16'h1111, 3'd1, 1'b1, 1'b1, 0, 0);
        add_cmd(4'd15, 1'b0, 6'd0, 2'd0, 16'h0000, 3'd0, 1'b0, 1'b0, 0, 0);

        // random part, in stretches with and without gaps
        calm = 1'b0;
        for (n = 0; n < 84; n++)
        begin
            if (n % 20 == 0)
                calm = ($urandom_range(0, 2) == 0);
            add_random_cmd(calm, n == 0 || n == 42 || n == 80);
        end
        total_cmds = cmd_q.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (tx_taken < total_cmds || lcd_xfer_q.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Ran %0d commands: %0d decimal, %0d hex, %0d clear row, %0d unused codes",
                 total_cmds, cmd_count[CMD_DECIMAL],
                 cmd_count[CMD_HEX_BYTE] + cmd_count[CMD_HEX_WORD],
                 cmd_count[CMD_CLEAR_ROW],
                 cmd_count[9] + cmd_count[10] + cmd_count[11] + cmd_count[12]
                 + cmd_count[13] + cmd_count[14] + cmd_count[15]);
        $display("Checked %0d nibble transfers with random gaps and back-pressure, %0d mismatches",
                 rx_taken, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d commands taken and %0d transfers outstanding",
                 tx_taken, lcd_xfer_q.size());
        $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/clcd_pkg.sv
rtl/core/char_lcd_text_writer.sv
dv/tb_top.sv
